// ----- hdl/i2cm_pkg.sv -----
// ---------------------------------------------------------------------------
// i2cm_pkg
// Shared codes and result type for the I2C register access master.
// ---------------------------------------------------------------------------
package i2cm_pkg;

  // input actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  // bus phases
  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_S1        = 5'd1;
  localparam logic [4:0] PH_S2        = 5'd2;
  localparam logic [4:0] PH_S3        = 5'd3;
  localparam logic [4:0] PH_S4        = 5'd4;
  localparam logic [4:0] PH_TX_LOW    = 5'd5;
  localparam logic [4:0] PH_TX_HIGH   = 5'd6;
  localparam logic [4:0] PH_ACK_LOW   = 5'd7;
  localparam logic [4:0] PH_ACK_HIGH  = 5'd8;
  localparam logic [4:0] PH_ACK_POLL  = 5'd9;
  localparam logic [4:0] PH_RX_LOW    = 5'd10;
  localparam logic [4:0] PH_RX_HIGH   = 5'd11;
  localparam logic [4:0] PH_MACK_LOW  = 5'd12;
  localparam logic [4:0] PH_MACK_HIGH = 5'd13;
  localparam logic [4:0] PH_MACK_END  = 5'd14;
  localparam logic [4:0] PH_P1        = 5'd15;
  localparam logic [4:0] PH_P2        = 5'd16;
  localparam logic [4:0] PH_P3        = 5'd17;

  // byte being sent
  localparam logic [1:0] ST_ADDR_W = 2'd0;
  localparam logic [1:0] ST_REG    = 2'd1;
  localparam logic [1:0] ST_DATA   = 2'd2;
  localparam logic [1:0] ST_ADDR_R = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ADDR_NAK = 2'd1;
  localparam logic [1:0] STAT_REG_NAK  = 2'd2;
  localparam logic [1:0] STAT_DATA_NAK = 2'd3;

  // configuration register indexes
  localparam logic [3:0] CFG_DEV_ADDR  = 4'd0;
  localparam logic [3:0] CFG_ACK_LIMIT = 4'd1;

  localparam logic [9:0] ACK_LIMIT_RST = 10'd500;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

// ----- hdl/i2cm_write_buf.sv -----
// ---------------------------------------------------------------------------
// i2cm_write_buf
// Write data buffer: one write port, one registered read port.
// ---------------------------------------------------------------------------
module i2cm_write_buf #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/i2cm_out_queue.sv -----
// ---------------------------------------------------------------------------
// i2cm_out_queue
// Two-entry result queue between the bus engine and the output channel.
// ---------------------------------------------------------------------------
module i2cm_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  i2cm_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output i2cm_pkg::result_t out_data_o
);
  import i2cm_pkg::*;

  result_t    ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ----- hdl/i2c_master_register_access_top.sv -----
// ---------------------------------------------------------------------------
// i2c_master_register_access_top
// Pin-level I2C master running one register write or read transaction.
// ---------------------------------------------------------------------------
// Every accepted input transfer (load, start write, start read or bus tick)
// is handled at the accepting edge: the bus phase and line drives update and
// one result transfer is queued. A transfer can be accepted in every cycle
// while in_stall_o is low. Results pass through a two-entry output queue, so
// in_stall_o rises only when both entries wait on a stalled output channel.
// Each tick is one half SCL period; scl_level_o/sda_level_o give the drives
// after that tick (1 released, 0 pulled low). Load write bytes while idle,
// then issue start write or start read with reg_address_i and byte_count_i.
// Data bytes come from a buffer of BUFFER_DEPTH entries with a registered read
// port that holds the first entry until data goes out and then looks one
// entry ahead of the send pointer. Configuration writes are always ready and
// apply at the accepting edge.
// ---------------------------------------------------------------------------
module i2c_master_register_access_top #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [7:0] reg_address_i,
  input  logic [7:0] write_byte_i,
  input  logic [4:0] byte_count_i,
  input  logic       sda_in_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_level_o,
  output logic       sda_level_o,
  output logic [7:0] read_byte_o,
  output logic       read_valid_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [1:0] status_o,
  // configuration channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_index_i,
  input  logic [9:0] cfg_data_i
);
  import i2cm_pkg::*;

  // pointer width holds 0..BUFFER_DEPTH, address width indexes the buffer
  localparam int PW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);

  // configuration
  logic [6:0] dev_addr_q;
  logic [9:0] ack_limit_q;

  // bus engine state
  logic [4:0]    phase_q, phase_d;
  logic [2:0]    bit_idx_q, bit_idx_d;
  logic [7:0]    shift_q, shift_d;
  logic [4:0]    bytes_left_q, bytes_left_d;
  logic [PW-1:0] load_ptr_q, load_ptr_d;
  logic [PW-1:0] send_idx_q, send_idx_d;
  logic [9:0]    ack_cnt_q, ack_cnt_d;
  logic [7:0]    saved_reg_q, saved_reg_d;
  logic [1:0]    status_q, status_d;
  logic          scl_q, scl_d;
  logic          sda_q, sda_d;
  logic [1:0]    stage_q, stage_d;
  logic          is_read_q, is_read_d;

  logic          accept;
  logic          queue_full;
  logic          buf_wr;
  logic [AW-1:0] buf_rd_addr;
  logic [7:0]    buf_rd_data;
  result_t       res, out_res;

  // scratch for the ack handling
  logic [4:0]    bl_dec;
  logic [PW-1:0] si_inc;
  logic [9:0]    ack_cnt_inc;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = queue_full;
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= 7'd0;
      ack_limit_q <= ACK_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEV_ADDR:  dev_addr_q  <= cfg_data_i[6:0];
        CFG_ACK_LIMIT: ack_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // loads only land while idle and the buffer has room
  assign buf_wr = accept && (action_i == ACT_LOAD) && (phase_q == PH_IDLE)
                  && (load_ptr_q < DEPTH_P);

  // first entry while the address and register go out, next entry during data
  assign buf_rd_addr = (stage_q == ST_DATA) ? si_inc[AW-1:0] : send_idx_q[AW-1:0];

  i2cm_write_buf #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (buf_wr),
    .wr_addr_i (load_ptr_q[AW-1:0]),
    .wr_data_i (write_byte_i),
    .rd_addr_i (buf_rd_addr),
    .rd_data_o (buf_rd_data)
  );

  // combinational phase update for one accepted transfer
  always_comb begin
    phase_d      = phase_q;
    bit_idx_d    = bit_idx_q;
    shift_d      = shift_q;
    bytes_left_d = bytes_left_q;
    load_ptr_d   = load_ptr_q;
    send_idx_d   = send_idx_q;
    ack_cnt_d    = ack_cnt_q;
    saved_reg_d  = saved_reg_q;
    status_d     = status_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    stage_d      = stage_q;
    is_read_d    = is_read_q;
    res          = '0;

    bl_dec      = (bytes_left_q != 5'd0) ? bytes_left_q - 5'd1 : bytes_left_q;
    si_inc      = send_idx_q + PW'(1);
    ack_cnt_inc = (ack_cnt_q != 10'h3FF) ? ack_cnt_q + 10'd1 : ack_cnt_q;

    if (accept) begin
      case (action_i)
        ACT_LOAD: begin
          if (buf_wr) load_ptr_d = load_ptr_q + PW'(1);
        end
        ACT_WRITE, ACT_READ: begin
          if (phase_q == PH_IDLE) begin
            is_read_d   = (action_i == ACT_READ);
            saved_reg_d = reg_address_i;
            if (action_i == ACT_READ) begin
              bytes_left_d = (byte_count_i == 5'd0) ? 5'd1 : byte_count_i;
            end else begin
              // clamp to buffer depth
              bytes_left_d = (int'(byte_count_i) > BUFFER_DEPTH) ?
                             5'(BUFFER_DEPTH) : byte_count_i;
              load_ptr_d   = '0;
            end
            send_idx_d = '0;
            stage_d    = ST_ADDR_W;
            shift_d    = {dev_addr_q, 1'b0};
            bit_idx_d  = 3'd0;
            ack_cnt_d  = 10'd0;
            status_d   = STAT_OK;
            phase_d    = PH_S1;
          end
        end
        default: begin
          // bus tick
          case (phase_q)
            PH_S1: begin sda_d = 1'b1; phase_d = PH_S2; end
            PH_S2: begin scl_d = 1'b1; phase_d = PH_S3; end
            PH_S3: begin sda_d = 1'b0; phase_d = PH_S4; end
            PH_S4: begin scl_d = 1'b0; bit_idx_d = 3'd0; phase_d = PH_TX_LOW; end
            PH_TX_LOW: begin
              scl_d   = 1'b0;
              sda_d   = shift_q[7];
              phase_d = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
              scl_d     = 1'b1;
              shift_d   = {shift_q[6:0], 1'b0};
              bit_idx_d = bit_idx_q + 3'd1;
              phase_d   = (bit_idx_q == 3'd7) ? PH_ACK_LOW : PH_TX_LOW;
            end
            PH_ACK_LOW:  begin scl_d = 1'b0; sda_d = 1'b1; phase_d = PH_ACK_HIGH; end
            PH_ACK_HIGH: begin scl_d = 1'b1; ack_cnt_d = 10'd0; phase_d = PH_ACK_POLL; end
            PH_ACK_POLL: begin
              if (!sda_in_i) begin
                // acknowledged: move on to the next byte
                scl_d = 1'b0;
                case (stage_q)
                  ST_ADDR_W: begin
                    shift_d   = saved_reg_q;
                    stage_d   = ST_REG;
                    bit_idx_d = 3'd0;
                    phase_d   = PH_TX_LOW;
                  end
                  ST_REG: begin
                    if (is_read_q) begin
                      stage_d = ST_ADDR_R;
                      shift_d = {dev_addr_q, 1'b1};
                      phase_d = PH_S1;
                    end else if (bytes_left_q != 5'd0 && send_idx_q < DEPTH_P) begin
                      shift_d   = buf_rd_data;
                      stage_d   = ST_DATA;
                      bit_idx_d = 3'd0;
                      phase_d   = PH_TX_LOW;
                    end else begin
                      phase_d = PH_P1;
                    end
                  end
                  ST_DATA: begin
                    bytes_left_d = bl_dec;
                    send_idx_d   = si_inc;
                    if (bl_dec != 5'd0 && si_inc < DEPTH_P) begin
                      // read port already holds the entry after the one just sent
                      shift_d   = buf_rd_data;
                      bit_idx_d = 3'd0;
                      phase_d   = PH_TX_LOW;
                    end else begin
                      phase_d = PH_P1;
                    end
                  end
                  default: begin
                    shift_d   = 8'd0;
                    bit_idx_d = 3'd0;
                    phase_d   = PH_RX_LOW;
                  end
                endcase
              end else begin
                ack_cnt_d = ack_cnt_inc;
                if (ack_cnt_inc >= ack_limit_q) begin
                  scl_d   = 1'b0;
                  phase_d = PH_P1;
                  case (stage_q)
                    ST_REG:  status_d = STAT_REG_NAK;
                    ST_DATA: status_d = STAT_DATA_NAK;
                    default: status_d = STAT_ADDR_NAK;
                  endcase
                end
              end
            end
            PH_RX_LOW: begin scl_d = 1'b0; sda_d = 1'b1; phase_d = PH_RX_HIGH; end
            PH_RX_HIGH: begin
              scl_d     = 1'b1;
              shift_d   = {shift_q[6:0], sda_in_i};
              bit_idx_d = bit_idx_q + 3'd1;
              if (bit_idx_q == 3'd7) begin
                res.read_byte  = {shift_q[6:0], sda_in_i};
                res.read_valid = 1'b1;
                phase_d        = PH_MACK_LOW;
              end else begin
                phase_d = PH_RX_LOW;
              end
            end
            PH_MACK_LOW: begin
              // nack on the last byte
              scl_d   = 1'b0;
              sda_d   = (bytes_left_q <= 5'd1);
              phase_d = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin scl_d = 1'b1; phase_d = PH_MACK_END; end
            PH_MACK_END: begin
              scl_d        = 1'b0;
              bytes_left_d = bl_dec;
              if (bl_dec != 5'd0) begin
                shift_d   = 8'd0;
                bit_idx_d = 3'd0;
                phase_d   = PH_RX_LOW;
              end else begin
                phase_d = PH_P1;
              end
            end
            PH_P1: begin scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_P2; end
            PH_P2: begin scl_d = 1'b1; phase_d = PH_P3; end
            PH_P3: begin
              sda_d        = 1'b1;
              res.done_res = 1'b1;
              phase_d      = PH_IDLE;
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      endcase
    end

    res.scl_level = scl_d;
    res.sda_level = sda_d;
    res.busy_res  = (phase_d != PH_IDLE);
    res.status    = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_idx_q    <= 3'd0;
      shift_q      <= 8'd0;
      bytes_left_q <= 5'd0;
      load_ptr_q   <= '0;
      send_idx_q   <= '0;
      ack_cnt_q    <= 10'd0;
      saved_reg_q  <= 8'd0;
      status_q     <= STAT_OK;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      stage_q      <= ST_ADDR_W;
      is_read_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      bit_idx_q    <= bit_idx_d;
      shift_q      <= shift_d;
      bytes_left_q <= bytes_left_d;
      load_ptr_q   <= load_ptr_d;
      send_idx_q   <= send_idx_d;
      ack_cnt_q    <= ack_cnt_d;
      saved_reg_q  <= saved_reg_d;
      status_q     <= status_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      stage_q      <= stage_d;
      is_read_q    <= is_read_d;
    end
  end

  // result queue decouples the output stall from input acceptance
  i2cm_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .full_o      (queue_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign scl_level_o  = out_res.scl_level;
  assign sda_level_o  = out_res.sda_level;
  assign read_byte_o  = out_res.read_byte;
  assign read_valid_o = out_res.read_valid;
  assign busy_res_o   = out_res.busy_res;
  assign done_res_o   = out_res.done_res;
  assign status_o     = out_res.status;

endmodule
